// File: design/cccm_pkg.sv
// shared types, codes and constants for the condition mask builder
package cccm_pkg;

  localparam int MAX_MEMBERS   = 64;
  localparam int TABLE_ENTRIES = 256;

  localparam int CH_W        = 8;
  localparam int MASK_W      = 8;
  localparam int POS_W       = 8;
  localparam int TBL_IDX_W   = $clog2(TABLE_ENTRIES);
  localparam int SWEEP_W     = TBL_IDX_W + 1;
  localparam int MEM_IDX_W   = $clog2(MAX_MEMBERS);
  localparam int MEM_CNT_W   = $clog2(MAX_MEMBERS + 1);
  localparam int SEEN_W      = 2;

  localparam logic [1:0] CMD_CLEAR = 2'd0;
  localparam logic [1:0] CMD_CHAR  = 2'd1;
  localparam logic [1:0] CMD_READ  = 2'd2;

  localparam logic [CH_W-1:0] CH_OPEN  = 8'h5B;
  localparam logic [CH_W-1:0] CH_CARET = 8'h5E;
  localparam logic [CH_W-1:0] CH_CLOSE = 8'h5D;
  localparam logic [CH_W-1:0] CH_DOT   = 8'h2E;

  localparam logic [POS_W-1:0]  POS_MAX  = 8'd255;
  localparam logic [SEEN_W-1:0] SEEN_MAX = 2'd2;

  // what a pattern character does to the table
  typedef enum logic [2:0] {
    ACT_NONE,
    ACT_MEMBER,
    ACT_PLAIN,
    ACT_DOT,
    ACT_GROUP
  } act_t;

  // table port usage for one cycle
  typedef enum logic [2:0] {
    TOP_NONE,
    TOP_CLEAR,
    TOP_SWEEP,
    TOP_PT_RD,
    TOP_PT_WR,
    TOP_MEM_RD,
    TOP_MEM_WR,
    TOP_OUT_RD
  } tbl_op_t;

  typedef struct packed {
    logic    load;
    logic    exec;
    logic    clr_state;
    logic    cnt_clr;
    logic    cnt_step;
    logic    mem_rd;
    logic    mem_step;
    logic    finish;
    logic    out_load;
    tbl_op_t tbl_op;
  } ctl_cmd_t;

  typedef struct packed {
    logic [1:0] cmd;
    act_t       act;
    act_t       act_q;
    logic       negated;
    logic       sweep_done;
    logic       mem_done;
    logic       out_free;
  } ctl_sts_t;

endpackage

// File: design/char_class_condition_mask_builder_unit.sv
// Condition mask builder: one item per command, one result item per command.
// Work per item: a read only looks up the table, a plain char reads and writes one entry,
// a dot or a clear sweeps the whole table, a bracket group updates each member's entry, and a caret group sweeps first.
// One item at a time: the next item can be accepted from the cycle after its result loads,
// so a new item waits until the last result has loaded; a caret group with a full member list is the slowest item.
// Reset: synchronous rst_n; then a clearing pass over the whole table with in_stall high.
module char_class_condition_mask_builder_unit
  import cccm_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [1:0]        in_cmd,
  input  logic [CH_W-1:0]   in_ch,
  input  logic              in_last,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [MASK_W-1:0] out_mask,
  output logic [POS_W-1:0]  out_cond_count,
  output logic              out_in_group
);

  ctl_cmd_t cmd;
  ctl_sts_t sts;

  cccm_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  cccm_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .sts            (sts),
    .in_cmd         (in_cmd),
    .in_ch          (in_ch),
    .in_last        (in_last),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_mask       (out_mask),
    .out_cond_count (out_cond_count),
    .out_in_group   (out_in_group)
  );

endmodule

// File: design/cccm_ram.sv
// generic simple dual-port ram with registered read
module cccm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: design/cccm_ctrl.sv
// sequencer for clear sweeps, table updates, group application and readout
module cccm_ctrl
  import cccm_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  ctl_sts_t sts,
  output ctl_cmd_t cmd
);

  typedef enum logic [3:0] {
    S_INIT,
    S_IDLE,
    S_DECODE,
    S_CLR,
    S_SET,
    S_PT_RD,
    S_PT_WR,
    S_MEM_CHK,
    S_MEM_T,
    S_MEM_W,
    S_FIN,
    S_RD,
    S_OUT
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    cmd.tbl_op = TOP_NONE;
    case (state_r)
      S_INIT: begin
        cmd.tbl_op   = TOP_CLEAR;
        cmd.cnt_step = 1'b1;
        if (sts.sweep_done) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        cmd.cnt_clr = 1'b1;
        case (sts.cmd)
          CMD_CLEAR: begin
            cmd.clr_state = 1'b1;
            state_nxt     = S_CLR;
          end
          CMD_CHAR: begin
            cmd.exec = 1'b1;
            case (sts.act)
              ACT_PLAIN: state_nxt = S_PT_RD;
              ACT_DOT:   state_nxt = S_SET;
              ACT_GROUP: state_nxt = sts.negated ? S_SET : S_MEM_CHK;
              default:   state_nxt = S_RD;
            endcase
          end
          default: state_nxt = S_RD;
        endcase
      end
      S_CLR: begin
        cmd.tbl_op   = TOP_CLEAR;
        cmd.cnt_step = 1'b1;
        if (sts.sweep_done) begin
          state_nxt = S_RD;
        end
      end
      S_SET: begin
        cmd.tbl_op   = TOP_SWEEP;
        cmd.cnt_step = 1'b1;
        if (sts.sweep_done) begin
          state_nxt = (sts.act_q == ACT_GROUP) ? S_MEM_CHK : S_FIN;
        end
      end
      S_PT_RD: begin
        cmd.tbl_op = TOP_PT_RD;
        state_nxt  = S_PT_WR;
      end
      S_PT_WR: begin
        cmd.tbl_op = TOP_PT_WR;
        state_nxt  = S_FIN;
      end
      S_MEM_CHK: begin
        if (sts.mem_done) begin
          state_nxt = S_FIN;
        end else begin
          cmd.mem_rd = 1'b1;
          state_nxt  = S_MEM_T;
        end
      end
      S_MEM_T: begin
        cmd.tbl_op = TOP_MEM_RD;
        state_nxt  = S_MEM_W;
      end
      S_MEM_W: begin
        cmd.tbl_op   = TOP_MEM_WR;
        cmd.mem_step = 1'b1;
        state_nxt    = S_MEM_CHK;
      end
      S_FIN: begin
        cmd.finish = 1'b1;
        state_nxt  = S_RD;
      end
      S_RD: begin
        cmd.tbl_op = TOP_OUT_RD;
        state_nxt  = S_OUT;
      end
      S_OUT: begin
        // wait for the output register to free up
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_INIT;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_stall = (state_r != S_IDLE);

endmodule

// File: design/cccm_dp.sv
// datapath: pattern state, member list, mask table and output register
module cccm_dp
  import cccm_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  ctl_cmd_t          cmd,
  output ctl_sts_t          sts,
  input  logic [1:0]        in_cmd,
  input  logic [CH_W-1:0]   in_ch,
  input  logic              in_last,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [MASK_W-1:0] out_mask,
  output logic [POS_W-1:0]  out_cond_count,
  output logic              out_in_group
);

  // held item
  logic [1:0]      cmd_r;
  logic [CH_W-1:0] ch_r;
  logic            last_r;

  logic [POS_W-1:0]     pos_cnt_r, pos_cnt_nxt;
  logic                 group_open_r, group_open_nxt;
  logic                 negated_r, negated_nxt;
  logic [MEM_CNT_W-1:0] member_cnt_r, member_cnt_nxt;
  logic [SEEN_W-1:0]    seen_r, seen_nxt;
  logic [SWEEP_W-1:0]   sw_cnt_r, sw_cnt_nxt;
  logic [MEM_CNT_W-1:0] mem_idx_r, mem_idx_nxt;
  act_t                 act_r, act_nxt;
  logic                 out_valid_r, out_valid_nxt;

  logic [CH_W-1:0]   mem_addr_r;
  logic [MASK_W-1:0] out_mask_r;
  logic [POS_W-1:0]  out_count_r;
  logic              out_group_r;

  act_t              act;
  logic              lone_dot;
  logic [MASK_W-1:0] pos_bit;
  logic [CH_W-1:0]   plain_addr;
  logic [SWEEP_W-1:0] sw_prev;

  logic                 mem_we;
  logic [CH_W-1:0]      mem_rdata;
  logic                 tbl_we, tbl_re;
  logic [TBL_IDX_W-1:0] tbl_waddr, tbl_raddr;
  logic [MASK_W-1:0]    tbl_wdata, tbl_rdata;

  assign lone_dot   = (seen_r == '0) && last_r && (ch_r == CH_DOT);
  assign pos_bit    = (pos_cnt_r[POS_W-1:3] == '0) ?
                      (MASK_W'(1) << pos_cnt_r[2:0]) : '0;
  // a lone closing bracket lands on entry zero
  assign plain_addr = (ch_r == CH_CLOSE) ? '0 : ch_r;
  assign sw_prev    = sw_cnt_r - SWEEP_W'(1);

  always_comb begin
    act = ACT_NONE;
    if (!lone_dot) begin
      if (ch_r == CH_OPEN) begin
        act = ACT_NONE;
      end else if (group_open_r && ch_r == CH_CARET) begin
        act = ACT_NONE;
      end else if (ch_r == CH_CLOSE) begin
        act = group_open_r ? ACT_GROUP : ACT_PLAIN;
      end else if (ch_r != '0) begin
        if (group_open_r) begin
          act = ACT_MEMBER;
        end else begin
          act = (ch_r == CH_DOT) ? ACT_DOT : ACT_PLAIN;
        end
      end
    end
  end

  assign mem_we = cmd.exec && act == ACT_MEMBER &&
                  member_cnt_r < MEM_CNT_W'(MAX_MEMBERS);

  always_comb begin
    pos_cnt_nxt    = pos_cnt_r;
    group_open_nxt = group_open_r;
    negated_nxt    = negated_r;
    member_cnt_nxt = member_cnt_r;
    seen_nxt       = seen_r;
    sw_cnt_nxt     = sw_cnt_r;
    mem_idx_nxt    = mem_idx_r;
    act_nxt        = act_r;
    out_valid_nxt  = out_valid_r;

    if (cmd.clr_state) begin
      pos_cnt_nxt    = '0;
      group_open_nxt = 1'b0;
      negated_nxt    = 1'b0;
      member_cnt_nxt = '0;
      seen_nxt       = '0;
    end

    if (cmd.exec) begin
      act_nxt = act;
      if (seen_r < SEEN_MAX) begin
        seen_nxt = seen_r + SEEN_W'(1);
      end
      if (!lone_dot) begin
        if (ch_r == CH_OPEN) begin
          group_open_nxt = 1'b1;
        end else if (group_open_r && ch_r == CH_CARET) begin
          negated_nxt = 1'b1;
        end
      end
      if (mem_we) begin
        member_cnt_nxt = member_cnt_r + MEM_CNT_W'(1);
      end
    end

    if (cmd.finish) begin
      if (pos_cnt_r != POS_MAX) begin
        pos_cnt_nxt = pos_cnt_r + POS_W'(1);
      end
      if (act_r == ACT_GROUP) begin
        group_open_nxt = 1'b0;
        negated_nxt    = 1'b0;
        member_cnt_nxt = '0;
      end
    end

    if (cmd.cnt_clr) begin
      sw_cnt_nxt  = '0;
      mem_idx_nxt = '0;
    end else begin
      if (cmd.cnt_step && !sts.sweep_done) begin
        sw_cnt_nxt = sw_cnt_r + SWEEP_W'(1);
      end
      if (cmd.mem_step) begin
        mem_idx_nxt = mem_idx_r + MEM_CNT_W'(1);
      end
    end

    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_cnt_r    <= '0;
      group_open_r <= 1'b0;
      negated_r    <= 1'b0;
      member_cnt_r <= '0;
      seen_r       <= '0;
      sw_cnt_r     <= '0;
      mem_idx_r    <= '0;
      act_r        <= ACT_NONE;
      out_valid_r  <= 1'b0;
    end else begin
      pos_cnt_r    <= pos_cnt_nxt;
      group_open_r <= group_open_nxt;
      negated_r    <= negated_nxt;
      member_cnt_r <= member_cnt_nxt;
      seen_r       <= seen_nxt;
      sw_cnt_r     <= sw_cnt_nxt;
      mem_idx_r    <= mem_idx_nxt;
      act_r        <= act_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cmd_r  <= in_cmd;
      ch_r   <= in_ch;
      last_r <= in_last;
    end
    if (cmd.tbl_op == TOP_MEM_RD) begin
      mem_addr_r <= mem_rdata;
    end
    if (cmd.out_load) begin
      out_mask_r  <= tbl_rdata;
      out_count_r <= pos_cnt_r;
      out_group_r <= group_open_r;
    end
  end

  // table port steering
  always_comb begin
    tbl_we    = 1'b0;
    tbl_re    = 1'b0;
    tbl_waddr = '0;
    tbl_raddr = '0;
    tbl_wdata = '0;
    case (cmd.tbl_op)
      TOP_CLEAR: begin
        tbl_we    = !sw_cnt_r[SWEEP_W-1];
        tbl_waddr = sw_cnt_r[TBL_IDX_W-1:0];
      end
      TOP_SWEEP: begin
        // read entry k while writing back entry k-1
        tbl_re    = !sw_cnt_r[SWEEP_W-1];
        tbl_raddr = sw_cnt_r[TBL_IDX_W-1:0];
        tbl_we    = (sw_cnt_r != '0);
        tbl_waddr = sw_prev[TBL_IDX_W-1:0];
        tbl_wdata = tbl_rdata | pos_bit;
      end
      TOP_PT_RD: begin
        tbl_re    = 1'b1;
        tbl_raddr = plain_addr;
      end
      TOP_PT_WR: begin
        tbl_we    = 1'b1;
        tbl_waddr = plain_addr;
        tbl_wdata = tbl_rdata | pos_bit;
      end
      TOP_MEM_RD: begin
        tbl_re    = 1'b1;
        tbl_raddr = mem_rdata;
      end
      TOP_MEM_WR: begin
        tbl_we    = 1'b1;
        tbl_waddr = mem_addr_r;
        tbl_wdata = negated_r ? (tbl_rdata & ~pos_bit) : (tbl_rdata | pos_bit);
      end
      TOP_OUT_RD: begin
        tbl_re    = 1'b1;
        tbl_raddr = ch_r;
      end
      default: tbl_we = 1'b0;
    endcase
  end

  cccm_ram #(
    .WIDTH(CH_W),
    .DEPTH(MAX_MEMBERS)
  ) u_member_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (member_cnt_r[MEM_IDX_W-1:0]),
    .wdata (ch_r),
    .re    (cmd.mem_rd),
    .raddr (mem_idx_r[MEM_IDX_W-1:0]),
    .rdata (mem_rdata)
  );

  cccm_ram #(
    .WIDTH(MASK_W),
    .DEPTH(TABLE_ENTRIES)
  ) u_table_ram (
    .clk   (clk),
    .we    (tbl_we),
    .waddr (tbl_waddr),
    .wdata (tbl_wdata),
    .re    (tbl_re),
    .raddr (tbl_raddr),
    .rdata (tbl_rdata)
  );

  assign sts.cmd        = cmd_r;
  assign sts.act        = act;
  assign sts.act_q      = act_r;
  assign sts.negated    = negated_r;
  assign sts.sweep_done = (sw_cnt_r == SWEEP_W'(TABLE_ENTRIES));
  assign sts.mem_done   = (mem_idx_r == member_cnt_r);
  assign sts.out_free   = !out_valid_r || !out_stall;

  assign out_valid      = out_valid_r;
  assign out_mask       = out_mask_r;
  assign out_cond_count = out_count_r;
  assign out_in_group   = out_group_r;

  a_member_bound: assert property (@(posedge clk) disable iff (!rst_n)
    member_cnt_r <= MEM_CNT_W'(MAX_MEMBERS))
    else $error("member count past list depth");

  a_sweep_bound: assert property (@(posedge clk) disable iff (!rst_n)
    sw_cnt_r <= SWEEP_W'(TABLE_ENTRIES))
    else $error("sweep counter overran the table");

  a_group_closes: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish && act_r == ACT_GROUP |=> !group_open_r && member_cnt_r == '0)
    else $error("group still open after it was applied");

  a_pos_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
    !cmd.clr_state |=> pos_cnt_r >= $past(pos_cnt_r))
    else $error("position count dropped without a clear");

endmodule
